@@ rtl/assert_macros.svh @@
// Assertion macros shared by the arithmetic unit RTL.
// The macros expect signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/asmd_pkg.sv @@
// Shared types and constants for the signed add/sub/mul/div unit.
// Used by asmd_iter and signed_add_sub_mul_div_unit; depends on nothing.
`timescale 1ns / 1ps

package asmd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W = $clog2(DATA_WIDTH + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DATA_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]                   mode;
		logic signed [DATA_WIDTH-1:0] left_operand;
		logic signed [DATA_WIDTH-1:0] right_operand;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] main_result;
		logic signed [DATA_WIDTH-1:0] remainder_value;
		logic                         divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic divide;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

@@ rtl/asmd_iter.sv @@
// Radix-2 iterative shift-add multiplier and restoring shift-subtract divider.
// One shared adder, one operand bit per cycle. Depends on asmd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asmd_iter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  asmd_pkg::iter_cmd_t                cmd,
	input  logic [asmd_pkg::DATA_WIDTH-1:0]    op_a,
	input  logic [asmd_pkg::DATA_WIDTH-1:0]    op_b,
	output asmd_pkg::iter_stat_t               stat,
	output logic [asmd_pkg::DATA_WIDTH-1:0]    main_word,
	output logic [asmd_pkg::DATA_WIDTH-1:0]    rem_word
);

	logic                              busy_q;
	logic                              done_q;
	logic [asmd_pkg::CNT_W-1:0]        cnt_q;
	logic                              div_q;
	logic [asmd_pkg::DATA_WIDTH-1:0]   acc_q;
	logic [asmd_pkg::DATA_WIDTH-1:0]   sh_q;
	logic [asmd_pkg::DATA_WIDTH-1:0]   opd_q;

	logic [asmd_pkg::DATA_WIDTH:0]     add_x;
	logic [asmd_pkg::DATA_WIDTH:0]     add_y;
	logic [asmd_pkg::DATA_WIDTH:0]     add_sum;

	// Multiply adds the multiplicand into the accumulator; divide subtracts the
	// divisor from the partial remainder with the next dividend bit shifted in.
	always_comb begin
		if (div_q) begin
			add_x = {acc_q, sh_q[asmd_pkg::DATA_WIDTH-1]};
			add_y = ~{1'b0, opd_q};
		end else begin
			add_x = {1'b0, acc_q};
			add_y = {1'b0, opd_q};
		end
		add_sum = add_x + add_y + {{asmd_pkg::DATA_WIDTH{1'b0}}, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= asmd_pkg::CNT_LOAD;
			end else if (busy_q) begin
				cnt_q <= cnt_q - asmd_pkg::CNT_LAST;
				if (cnt_q == asmd_pkg::CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q <= cmd.divide;
			acc_q <= '0;
			if (cmd.divide) begin
				sh_q  <= op_a;
				opd_q <= op_b;
			end else begin
				sh_q  <= op_b;
				opd_q <= op_a;
			end
		end else if (busy_q) begin
			if (div_q) begin
				// A clear borrow means the trial subtraction fits.
				if (!add_sum[asmd_pkg::DATA_WIDTH]) begin
					acc_q <= add_sum[asmd_pkg::DATA_WIDTH-1:0];
				end else begin
					acc_q <= add_x[asmd_pkg::DATA_WIDTH-1:0];
				end
				sh_q <= {sh_q[asmd_pkg::DATA_WIDTH-2:0], ~add_sum[asmd_pkg::DATA_WIDTH]};
			end else begin
				if (sh_q[0]) begin
					acc_q <= add_sum[asmd_pkg::DATA_WIDTH-1:0];
				end
				sh_q  <= {1'b0, sh_q[asmd_pkg::DATA_WIDTH-1:1]};
				opd_q <= {opd_q[asmd_pkg::DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign main_word = div_q ? sh_q : acc_q;
	assign rem_word  = acc_q;

	`ASMD_ASSERT_NOW(a_start_when_free, cmd.start, !busy_q, "start while iterating")
	`ASMD_ASSERT_NOW(a_done_ends_busy, done_q, !busy_q && (cnt_q == '0), "done while still busy")

endmodule

@@ rtl/signed_add_sub_mul_div_unit.sv @@
// Signed add/sub/mul/div unit, top level; uses asmd_pkg and asmd_iter.
// From accepted word to result word: add, subtract and a zero divisor go through the staging
// register to the output register; multiply and divide first run the one-bit-per-cycle loop.
// One word is in work at a time: a new word is taken only once the last result has moved to
// the output register, and a finished result may wait there while the next is taken.
// Reset (arst_n low, asynchronous) empties the unit and drops the output word.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_add_sub_mul_div_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  asmd_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output asmd_pkg::rsp_t  rsp
);

	// Control state.
	asmd_pkg::state_t      state_q;
	asmd_pkg::state_t      state_d;
	logic                  rsp_valid_q;

	// Per-word context captured when a word is accepted.
	logic                  div_q;
	logic                  qneg_q;
	logic                  rneg_q;

	// Finished result waiting for the output register, and the output register.
	logic [asmd_pkg::DATA_WIDTH-1:0] res_q;
	logic [asmd_pkg::DATA_WIDTH-1:0] rem_q;
	logic                            dz_q;
	asmd_pkg::rsp_t                  rsp_q;

	// Strobes from the control block.
	logic                  load_fast;
	logic                  load_core;
	logic                  load_out;
	logic                  out_free;

	// Operand views of the incoming word.
	logic [asmd_pkg::DATA_WIDTH-1:0] opnd_a;
	logic [asmd_pkg::DATA_WIDTH-1:0] opnd_b;
	logic [asmd_pkg::DATA_WIDTH-1:0] mag_a;
	logic [asmd_pkg::DATA_WIDTH-1:0] mag_b;
	logic                            b_zero;
	logic [asmd_pkg::DATA_WIDTH-1:0] fast_res;

	// Iterative unit interface.
	asmd_pkg::iter_cmd_t             cmd;
	asmd_pkg::iter_stat_t            stat;
	logic [asmd_pkg::DATA_WIDTH-1:0] core_a;
	logic [asmd_pkg::DATA_WIDTH-1:0] core_b;
	logic [asmd_pkg::DATA_WIDTH-1:0] core_main;
	logic [asmd_pkg::DATA_WIDTH-1:0] core_rem;

	// The divider works on unsigned magnitudes, so the most negative value
	// (whose magnitude needs the full unsigned width) divides correctly.
	assign opnd_a = req.left_operand;
	assign opnd_b = req.right_operand;
	assign mag_a  = opnd_a[asmd_pkg::DATA_WIDTH-1] ? (~opnd_a + 1'b1) : opnd_a;
	assign mag_b  = opnd_b[asmd_pkg::DATA_WIDTH-1] ? (~opnd_b + 1'b1) : opnd_b;
	assign b_zero = (opnd_b == '0);

	// Add and subtract finish in the accept cycle. A zero divisor also takes
	// this path and returns zero for both quotient and remainder.
	always_comb begin
		case (req.mode)
			asmd_pkg::MODE_ADD: fast_res = opnd_a + opnd_b;
			asmd_pkg::MODE_SUB: fast_res = opnd_a - opnd_b;
			default:            fast_res = '0;
		endcase
	end

	// Multiply feeds the raw operands; the low product bits are the same for
	// signed and unsigned operands. Divide feeds the magnitudes.
	assign core_a     = (req.mode == asmd_pkg::MODE_DIV) ? mag_a : opnd_a;
	assign core_b     = (req.mode == asmd_pkg::MODE_DIV) ? mag_b : opnd_b;

	// The output register can take a new word when it is empty or its word is
	// being taken in this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asmd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes. Input words are taken only in the idle state,
	// which the unit reaches again as soon as the result has moved to the
	// output register, even if that word is still stalled there.
	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.divide = (req.mode == asmd_pkg::MODE_DIV);
		load_fast  = 1'b0;
		load_core  = 1'b0;
		load_out   = 1'b0;
		req_stall  = 1'b1;
		unique case (state_q)
			asmd_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if ((req.mode == asmd_pkg::MODE_MUL) ||
					    ((req.mode == asmd_pkg::MODE_DIV) && !b_zero)) begin
						cmd.start = 1'b1;
						state_d   = asmd_pkg::ST_RUN;
					end else begin
						load_fast = 1'b1;
						state_d   = asmd_pkg::ST_DONE;
					end
				end
			end
			asmd_pkg::ST_RUN: begin
				if (stat.done) begin
					load_core = 1'b1;
					state_d   = asmd_pkg::ST_DONE;
				end
			end
			asmd_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = asmd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = asmd_pkg::ST_IDLE;
			end
		endcase
	end

	// Result staging. The quotient takes its sign from the operand signs and
	// the remainder takes the dividend's sign; both are fixed up here once the
	// iteration is over.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q  <= cmd.divide;
			qneg_q <= opnd_a[asmd_pkg::DATA_WIDTH-1] ^ opnd_b[asmd_pkg::DATA_WIDTH-1];
			rneg_q <= opnd_a[asmd_pkg::DATA_WIDTH-1];
		end
		if (load_fast) begin
			res_q <= fast_res;
			rem_q <= '0;
			dz_q  <= (req.mode == asmd_pkg::MODE_DIV);
		end else if (load_core) begin
			dz_q <= 1'b0;
			if (div_q) begin
				res_q <= qneg_q ? (~core_main + 1'b1) : core_main;
				rem_q <= rneg_q ? (~core_rem + 1'b1) : core_rem;
			end else begin
				res_q <= core_main;
				rem_q <= '0;
			end
		end
	end

	// Output register: parts the result side from the work in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q.main_result     <= res_q;
			rsp_q.remainder_value <= rem_q;
			rsp_q.divide_by_zero  <= dz_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	asmd_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op_a      (core_a),
		.op_b      (core_b),
		.stat      (stat),
		.main_word (core_main),
		.rem_word  (core_rem)
	);

	`ASMD_ASSERT_NOW(a_run_has_core, state_q == asmd_pkg::ST_RUN, stat.busy || stat.done,
		"run state without active iteration")
	`ASMD_ASSERT_NOW(a_dz_zero_result, rsp_valid_q && rsp_q.divide_by_zero,
		(rsp_q.main_result == '0) && (rsp_q.remainder_value == '0),
		"zero divisor with nonzero result")

endmodule

@@ test/tb_signed_add_sub_mul_div_unit.sv @@
// Self-checking testbench for signed_add_sub_mul_div_unit: add, subtract, multiply and divide.
// Needs asmd_pkg and the unit's RTL. A scoreboard class predicts each result word and
// checks it; random request gaps and random result stalls exercise the valid/stall handshake.
`timescale 1ns / 1ps

module tb_signed_add_sub_mul_div_unit;
	import asmd_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic signed [W-1:0] OP_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] OP_MAX = ~OP_MIN;
	// The limit covers the slowest correct run: the longest gap, the full multiply/divide
	// loop and the longest output stall on every word. It adds a wide margin on top of that.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS_PER_PHASE = 250;
	// The tail wait outlasts a full multiply/divide run, so that a stray late word is still seen.
	localparam int TAIL_CYCLES = DATA_WIDTH + 8;

	// Scoreboard: predicts the result word for each accepted request word, then
	// compares the unit's result words against the predictions in order.
	class arith_scoreboard;
		rsp_t expected_results[$];
		int   errors;
		int   mode_count[4];
		int   zero_divisors;
		int   results_checked;

		function new();
			errors = 0;
			zero_divisors = 0;
			results_checked = 0;
			foreach (mode_count[i])
				mode_count[i] = 0;
		endfunction

		// Magnitudes are handled as unsigned values, so the most negative operand
		// divides correctly. A zero divisor gives a zero quotient and remainder with
		// the flag raised.
		function rsp_t compute_result(req_t w);
			logic [W-1:0] a, b, mag_a, mag_b, quo, rem;
			rsp_t r;
			a = w.left_operand;
			b = w.right_operand;
			r = '0;
			case (w.mode)
				MODE_ADD: r.main_result = a + b;
				MODE_SUB: r.main_result = a - b;
				MODE_MUL: r.main_result = a * b;
				MODE_DIV: begin
					if (b == '0) begin
						r.divide_by_zero = 1'b1;
					end else begin
						mag_a = a[W-1] ? -a : a;
						mag_b = b[W-1] ? -b : b;
						quo = mag_a / mag_b;
						rem = mag_a % mag_b;
						r.main_result = (a[W-1] ^ b[W-1]) ? -quo : quo;
						r.remainder_value = a[W-1] ? -rem : rem;
					end
				end
			endcase
			return r;
		endfunction

		function void note_request(req_t w);
			expected_results.push_back(compute_result(w));
			mode_count[w.mode]++;
			if (w.mode == MODE_DIV && w.right_operand == '0)
				zero_divisors++;
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_results.size() == 0) begin
				$error("result word with no request pending: main_result %0d", got.main_result);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			if (got.main_result !== want.main_result) begin
				$error("main_result: expected %0d, got %0d", want.main_result, got.main_result);
				errors++;
			end
			if (got.remainder_value !== want.remainder_value) begin
				$error("remainder_value: expected %0d, got %0d",
					want.remainder_value, got.remainder_value);
				errors++;
			end
			if (got.divide_by_zero !== want.divide_by_zero) begin
				$error("divide_by_zero: expected %0b, got %0b",
					want.divide_by_zero, got.divide_by_zero);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	arith_scoreboard board;
	int unsigned cycle_count = 0;
	// The largest gap or stall drawn per word. It is set to zero for a stretch with no idling.
	int idle_limit = 13;

	signed_add_sub_mul_div_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Watch both channels at the rising edge. Inputs move only on the falling edge,
	// so the values seen here are the ones the unit sees.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_request(req);
			if (rsp_valid && !rsp_stall)
				board.check_result(rsp);
		end
	end

	// Draw an operand biased toward the values that break arithmetic: the extremes,
	// zero, plus and minus one, small numbers and powers of two. About a third of
	// the draws are full-width random values, so that every bit toggles.
	function automatic logic signed [W-1:0] pick_operand();
		logic signed [W-1:0] v;
		case ($urandom_range(0, 15))
			0: v = OP_MIN;
			1: v = OP_MAX;
			2: v = '0;
			3: v = -1;
			4: v = 1;
			5, 6, 7: v = W'($signed($urandom_range(0, 32)) - 16);
			8, 9: begin
				v = W'(1) << $urandom_range(0, W - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = W'({$urandom, $urandom});
		endcase
		return v;
	endfunction

	// Present one request word, after a random gap, and hold it until it is taken.
	// The task is entered and left at a falling edge. The valid line is lowered only
	// when a gap follows, so it never gets two updates in one step.
	task automatic send_word(input logic [1:0] mode, input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		int gap;
		req_t w;
		gap = $urandom_range(0, idle_limit);
		w.mode = mode;
		w.left_operand = a;
		w.right_operand = b;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Lower valid, then wait at falling edges until every predicted result has been checked.
	task automatic drain();
		req_valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	// Output stall: before each result word, stall for a random number of cycles.
	// The stall can run out while the unit is still busy, so it lands on every phase
	// of the loop. After that, accept the next word as soon as it shows up.
	initial begin : rsp_backpressure
		int hold;
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, idle_limit);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && rsp_valid));
			@(negedge clk);
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("signed_add_sub_mul_div_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int n;
		logic [1:0] mode;
		board = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words. Wrapping sums, differences and products come first.
		send_word(MODE_ADD, OP_MAX, 1);
		send_word(MODE_ADD, OP_MIN, OP_MIN);
		send_word(MODE_ADD, 0, 0);
		send_word(MODE_SUB, OP_MIN, 1);
		send_word(MODE_SUB, OP_MAX, -1);
		send_word(MODE_SUB, 0, OP_MIN);
		send_word(MODE_MUL, OP_MAX, OP_MAX);
		send_word(MODE_MUL, OP_MIN, -1);
		send_word(MODE_MUL, -1, -1);
		send_word(MODE_MUL, 32'sh0001_0000, 32'sh0001_0000);
		// Division covers every sign combination of a truncating quotient. It also
		// covers the most negative dividend and each zero-divisor case.
		send_word(MODE_DIV, 7, 2);
		send_word(MODE_DIV, -7, 2);
		send_word(MODE_DIV, 7, -2);
		send_word(MODE_DIV, -7, -2);
		send_word(MODE_DIV, OP_MIN, -1);
		send_word(MODE_DIV, OP_MIN, 1);
		send_word(MODE_DIV, OP_MAX, OP_MIN);
		send_word(MODE_DIV, OP_MIN, OP_MIN);
		send_word(MODE_DIV, OP_MIN, OP_MAX);
		send_word(MODE_DIV, 0, 5);
		send_word(MODE_DIV, -1, OP_MAX);
		send_word(MODE_DIV, 5, 0);
		send_word(MODE_DIV, OP_MIN, 0);
		send_word(MODE_DIV, 0, 0);

		// Hold the sender off until the unit has delivered every result. The next
		// phase therefore starts from an empty unit.
		drain();

		// Random phases: normal idling, then a stretch with no idling on either side,
		// then normal idling again.
		for (phase = 0; phase < 3; phase++) begin
			idle_limit = (phase == 1) ? 0 : 13;
			for (n = 0; n < RANDOM_WORDS_PER_PHASE; n++) begin
				mode = 2'($urandom_range(MODE_ADD, MODE_DIV));
				send_word(mode, pick_operand(), pick_operand());
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d result words: add %0d, subtract %0d, multiply %0d, divide %0d",
			board.results_checked, board.mode_count[MODE_ADD], board.mode_count[MODE_SUB],
			board.mode_count[MODE_MUL], board.mode_count[MODE_DIV]);
		$display("Divides by zero: %0d; failures found: %0d.", board.zero_divisors, board.errors);
		if (board.errors == 0)
			$display("signed_add_sub_mul_div_unit regression: pass");
		else
			$display("signed_add_sub_mul_div_unit regression: fail");
		$finish;
	end

endmodule
